### design/itpi_pkg.sv
// itpi_pkg: shared types and constants of the interval timer port interface
// no dependencies; used by itpi_regs and interval_timer_port_interface_top
`default_nettype none

package itpi_pkg;

  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;

  // register select codes
  localparam logic [1:0] SEL_CTRL = 2'd3;

  // bus operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // channel access modes (control word bits 5..4)
  typedef enum logic [1:0] {
    ACC_LATCH = 2'd0,
    ACC_LSB   = 2'd1,
    ACC_MSB   = 2'd2,
    ACC_LOHI  = 2'd3
  } acc_mode_t;

  // value returned on a read of the control register
  localparam logic [BYTE_W-1:0] CTRL_READ_VAL = 8'hFF;

  // one bus access as it travels from the input register to the register file
  typedef struct packed {
    logic              op;
    logic [1:0]        sel;
    logic [BYTE_W-1:0] wdata;
  } itpi_access_t;

endpackage

`default_nettype wire

### design/itpi_regs.sv
// itpi_regs: per-channel timer registers, control word decode and read byte select
// depends on itpi_pkg
`default_nettype none

module itpi_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         acc_en,
  input  wire itpi_pkg::itpi_access_t       acc,
  output logic [itpi_pkg::BYTE_W-1:0]       rd_data
);

  logic [itpi_pkg::COUNT_W-1:0] count_r    [itpi_pkg::NUM_CH];
  logic [itpi_pkg::COUNT_W-1:0] count_nxt  [itpi_pkg::NUM_CH];
  logic [itpi_pkg::COUNT_W-1:0] latch_r    [itpi_pkg::NUM_CH];
  logic [itpi_pkg::COUNT_W-1:0] latch_nxt  [itpi_pkg::NUM_CH];
  itpi_pkg::acc_mode_t          amode_r    [itpi_pkg::NUM_CH];
  itpi_pkg::acc_mode_t          amode_nxt  [itpi_pkg::NUM_CH];
  logic [2:0]                   omode_r    [itpi_pkg::NUM_CH];
  logic [2:0]                   omode_nxt  [itpi_pkg::NUM_CH];
  logic                         wph_r      [itpi_pkg::NUM_CH];
  logic                         wph_nxt    [itpi_pkg::NUM_CH];
  logic                         rph_r      [itpi_pkg::NUM_CH];
  logic                         rph_nxt    [itpi_pkg::NUM_CH];
  logic                         pend_r     [itpi_pkg::NUM_CH];
  logic                         pend_nxt   [itpi_pkg::NUM_CH];

  always_comb begin
    logic                         ctrl_hit;
    logic                         data_hit;
    logic [itpi_pkg::COUNT_W-1:0] v;
    itpi_pkg::acc_mode_t          new_acc;

    rd_data = ((acc.op == itpi_pkg::OP_READ) && (acc.sel == itpi_pkg::SEL_CTRL)) ?
              itpi_pkg::CTRL_READ_VAL : '0;
    new_acc = itpi_pkg::acc_mode_t'(acc.wdata[5:4]);

    for (int i = 0; i < itpi_pkg::NUM_CH; i++) begin
      count_nxt[i] = count_r[i];
      latch_nxt[i] = latch_r[i];
      amode_nxt[i] = amode_r[i];
      omode_nxt[i] = omode_r[i];
      wph_nxt[i]   = wph_r[i];
      rph_nxt[i]   = rph_r[i];
      pend_nxt[i]  = pend_r[i];

      ctrl_hit = (acc.op == itpi_pkg::OP_WRITE) && (acc.sel == itpi_pkg::SEL_CTRL) &&
                 (acc.wdata[7:6] == 2'(i));
      data_hit = (acc.sel == 2'(i));
      v = pend_r[i] ? latch_r[i] : count_r[i];

      if (ctrl_hit) begin
        if (new_acc == itpi_pkg::ACC_LATCH) begin
          latch_nxt[i] = count_r[i];
          pend_nxt[i]  = 1'b1;
          rph_nxt[i]   = 1'b0;
        end else begin
          amode_nxt[i] = new_acc;
          omode_nxt[i] = acc.wdata[3:1];
          wph_nxt[i]   = 1'b0;
          rph_nxt[i]   = 1'b0;
        end
      end else if (data_hit && (acc.op == itpi_pkg::OP_WRITE)) begin
        case (amode_r[i])
          itpi_pkg::ACC_LOHI: begin
            if (!wph_r[i]) begin
              count_nxt[i] = {count_r[i][15:8], acc.wdata};
              wph_nxt[i]   = 1'b1;
            end else begin
              count_nxt[i] = {acc.wdata, count_r[i][7:0]};
              wph_nxt[i]   = 1'b0;
            end
          end
          itpi_pkg::ACC_LSB: count_nxt[i] = {8'h00, acc.wdata};
          itpi_pkg::ACC_MSB: count_nxt[i] = {acc.wdata, 8'h00};
          default: ;
        endcase
      end else if (data_hit) begin
        // data read: byte order follows access mode and read phase
        if (amode_r[i] == itpi_pkg::ACC_LOHI) begin
          if (!rph_r[i]) begin
            rd_data    = v[7:0];
            rph_nxt[i] = 1'b1;
          end else begin
            rd_data     = v[15:8];
            rph_nxt[i]  = 1'b0;
            pend_nxt[i] = 1'b0;
          end
        end else begin
          pend_nxt[i] = 1'b0;
          rd_data = (amode_r[i] == itpi_pkg::ACC_LSB) ? v[7:0] : v[15:8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < itpi_pkg::NUM_CH; i++) begin
        count_r[i] <= '0;
        latch_r[i] <= '0;
        amode_r[i] <= itpi_pkg::ACC_LATCH;
        omode_r[i] <= '0;
        wph_r[i]   <= 1'b0;
        rph_r[i]   <= 1'b0;
        pend_r[i]  <= 1'b0;
      end
    end else if (acc_en) begin
      for (int i = 0; i < itpi_pkg::NUM_CH; i++) begin
        count_r[i] <= count_nxt[i];
        latch_r[i] <= latch_nxt[i];
        amode_r[i] <= amode_nxt[i];
        omode_r[i] <= omode_nxt[i];
        wph_r[i]   <= wph_nxt[i];
        rph_r[i]   <= rph_nxt[i];
        pend_r[i]  <= pend_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

### design/interval_timer_port_interface_top.sv
// interval_timer_port_interface_top: stream wrapper around the timer register file
// depends on itpi_pkg and itpi_regs
`default_nettype none

// register interface of a three-channel interval timer (no counting)
// each input item is one bus access: read or write of channel data
// register 0..2 or of the control word register 3
// every input item gives exactly one result item holding the read byte
// (255 for a control register read, 0 for any write)
// pipeline: input register, then the register file update and read byte
// select (combinational), then the result register
// throughput: one item per cycle while the receiver takes results;
// accesses may come back to back
// when the receiver stalls the result register holds, the input register
// fills, and in_tready drops only once both are full
// reset (rst_n low, synchronous) empties both registers and clears all
// channel state to zero

module interval_timer_port_interface_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input item
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [0] operation, [2:1] register_select, [10:3] write_data, [15:11] zero
  input  wire logic [itpi_pkg::IN_TDATA_W-1:0]      in_tdata,
  // result item
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [7:0] read_data
  output logic [itpi_pkg::OUT_TDATA_W-1:0]          out_tdata
);

  // input register
  itpi_pkg::itpi_access_t item_r;
  logic                   item_valid_r;
  logic                   item_valid_nxt;

  // result register
  logic [itpi_pkg::BYTE_W-1:0] res_r;
  logic                        res_valid_r;
  logic                        res_valid_nxt;

  logic                        advance;   // item moves into the result register
  logic                        in_fire;
  logic [itpi_pkg::BYTE_W-1:0] rd_byte;

  assign advance   = item_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign item_valid_nxt = in_fire || (item_valid_r && !advance);
  assign res_valid_nxt  = advance || (res_valid_r && !out_tready);

  // register file sees each access exactly once, when it advances
  itpi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_en  (advance),
    .acc     (item_r),
    .rd_data (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op    <= in_tdata[0];
      item_r.sel   <= in_tdata[2:1];
      item_r.wdata <= in_tdata[10:3];
    end
    if (advance) begin
      res_r <= rd_byte;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_r;

endmodule

`default_nettype wire

### tb/interval_timer_port_interface_top_test.sv
// interval_timer_port_interface_top_test: self-checking bench for the timer port interface
// drives bus accesses as stream items and checks each read byte against its own timer model
// depends on itpi_pkg and interval_timer_port_interface_top
`timescale 1ns / 1ps

module interval_timer_port_interface_top_test;

  // channel data register selects and the unused channel field of a control word
  localparam logic [1:0] SEL_CH0 = 2'd0;
  localparam logic [1:0] SEL_CH1 = 2'd1;
  localparam logic [1:0] SEL_CH2 = 2'd2;
  localparam logic [1:0] CH_NONE = 2'd3;

  localparam int unsigned MAX_WAIT   = 18;
  localparam int unsigned RANDOM_N   = 450;
  localparam int unsigned IDLE_LIMIT = 500;
  localparam int unsigned DRAIN_CYC  = 6;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    logic                        op;
    logic [1:0]                  sel;
    logic [itpi_pkg::BYTE_W-1:0] wdata;
    bit                          typed;
    logic [itpi_pkg::BYTE_W-1:0] want;
  } access_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [itpi_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [itpi_pkg::OUT_TDATA_W-1:0] out_tdata;

  interval_timer_port_interface_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // timer model state, one entry per channel
  logic [itpi_pkg::COUNT_W-1:0] tm_count   [itpi_pkg::NUM_CH];
  itpi_pkg::acc_mode_t          tm_acc     [itpi_pkg::NUM_CH];
  logic [2:0]                   tm_opmode  [itpi_pkg::NUM_CH];
  logic                         tm_wr_hi   [itpi_pkg::NUM_CH];
  logic                         tm_rd_hi   [itpi_pkg::NUM_CH];
  logic                         tm_held    [itpi_pkg::NUM_CH];
  logic [itpi_pkg::COUNT_W-1:0] tm_held_val[itpi_pkg::NUM_CH];

  // read bytes still owed by the block, oldest first
  logic [itpi_pkg::BYTE_W-1:0] owed_read_bytes[$];
  access_row_t                 directed_rows[$];

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          tx_burst = 0;
  bit          rx_burst = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // control word: [7:6] channel, [5:4] access mode, [3:1] operating mode, [0] bcd
  function automatic logic [itpi_pkg::BYTE_W-1:0] ctrl_word(input logic [1:0] ch,
                                                            input itpi_pkg::acc_mode_t acc,
                                                            input logic [2:0] mode);
    return {ch, acc, mode, 1'b0};
  endfunction

  // applies one bus access to the timer model and returns the byte the bus sees
  function automatic logic [itpi_pkg::BYTE_W-1:0] timer_access(
      input logic op, input logic [1:0] sel, input logic [itpi_pkg::BYTE_W-1:0] wdata);
    logic [1:0]                   ch;
    itpi_pkg::acc_mode_t          acc;
    logic [itpi_pkg::COUNT_W-1:0] src;
    ch = sel;
    if (op == itpi_pkg::OP_WRITE) begin
      if (sel == itpi_pkg::SEL_CTRL) begin
        ch  = wdata[7:6];
        acc = itpi_pkg::acc_mode_t'(wdata[5:4]);
        // a word for channel three changes nothing
        if (ch < itpi_pkg::NUM_CH) begin
          if (acc == itpi_pkg::ACC_LATCH) begin
            tm_held_val[ch] = tm_count[ch];
            tm_held[ch]     = 1'b1;
            tm_rd_hi[ch]    = 1'b0;
          end else begin
            tm_acc[ch]    = acc;
            tm_opmode[ch] = wdata[3:1];
            tm_wr_hi[ch]  = 1'b0;
            tm_rd_hi[ch]  = 1'b0;
          end
        end
      end else begin
        case (tm_acc[ch])
          itpi_pkg::ACC_LOHI: begin
            if (!tm_wr_hi[ch]) tm_count[ch][7:0] = wdata;
            else tm_count[ch][15:8] = wdata;
            tm_wr_hi[ch] = !tm_wr_hi[ch];
          end
          itpi_pkg::ACC_LSB: tm_count[ch] = {8'h00, wdata};
          itpi_pkg::ACC_MSB: tm_count[ch] = {wdata, 8'h00};
          default: ;
        endcase
      end
      return '0;
    end
    if (sel == itpi_pkg::SEL_CTRL) return itpi_pkg::CTRL_READ_VAL;
    src = tm_held[ch] ? tm_held_val[ch] : tm_count[ch];
    if (tm_acc[ch] == itpi_pkg::ACC_LOHI) begin
      if (!tm_rd_hi[ch]) begin
        tm_rd_hi[ch] = 1'b1;
        return src[7:0];
      end
      tm_rd_hi[ch] = 1'b0;
      tm_held[ch]  = 1'b0;
      return src[15:8];
    end
    tm_held[ch] = 1'b0;
    return (tm_acc[ch] == itpi_pkg::ACC_LSB) ? src[7:0] : src[15:8];
  endfunction

  // offers one access, waits for the handshake, then books the owed byte
  task automatic send_access(input logic op, input logic [1:0] sel,
                             input logic [itpi_pkg::BYTE_W-1:0] wdata, input bit typed,
                             input logic [itpi_pkg::BYTE_W-1:0] want);
    int unsigned                 gap;
    logic [itpi_pkg::BYTE_W-1:0] predicted;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
    // valid stays high across back-to-back items; it is only lowered for a real gap
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(itpi_pkg::IN_TDATA_W - itpi_pkg::BYTE_W - 3){1'b0}}, wdata, sel, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = timer_access(op, sel, wdata);
    owed_read_bytes.push_back(typed ? want : predicted);
  endtask

  // result side: random stalls, each accepted item checked against the oldest owed byte
  initial begin
    int unsigned                 stall;
    logic [itpi_pkg::BYTE_W-1:0] owed;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (owed_read_bytes.size() == 0) begin
        $error("unexpected item: read_data 0x%02h with nothing owed", out_tdata);
        fail_count++;
      end else begin
        owed = owed_read_bytes.pop_front();
        if (out_tdata !== owed) begin
          $error("read_data mismatch: expected 0x%02h, actual 0x%02h", owed, out_tdata);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic                        op;
    logic [1:0]                  sel;
    logic [itpi_pkg::BYTE_W-1:0] wdata;
    int unsigned                 pick;
    for (int i = 0; i < itpi_pkg::NUM_CH; i++) begin
      tm_count[i]    = '0;
      tm_acc[i]      = itpi_pkg::ACC_LATCH;
      tm_opmode[i]   = '0;
      tm_wr_hi[i]    = 1'b0;
      tm_rd_hi[i]    = 1'b0;
      tm_held[i]     = 1'b0;
      tm_held_val[i] = '0;
    end
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;

    // directed table: after reset, ignored writes, each access mode, latching
    // straddling a reload, channel-three control words and the control read
    // reset state: access mode latch reads the high byte of a zero count
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH0, 8'h00, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, itpi_pkg::SEL_CTRL, 8'hFF, 1'b1,
                            itpi_pkg::CTRL_READ_VAL});
    // data write while access mode is latch is dropped
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH1, 8'h55, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH1, 8'hAA, 1'b1, 8'h00});
    // control word for channel three is ignored
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, itpi_pkg::SEL_CTRL,
                            ctrl_word(CH_NONE, itpi_pkg::ACC_LOHI, 3'd7) | 8'h01,
                            1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH2, 8'h00, 1'b1, 8'h00});
    // low/high byte pairs on channel 0
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, itpi_pkg::SEL_CTRL,
                            ctrl_word(SEL_CH0, itpi_pkg::ACC_LOHI, 3'd7), 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH0, 8'hFF, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH0, 8'hA5, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH0, 8'h00, 1'b1, 8'hFF});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH0, 8'h00, 1'b1, 8'hA5});
    // latch, reload underneath, the latched count still comes out first
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, itpi_pkg::SEL_CTRL,
                            ctrl_word(SEL_CH0, itpi_pkg::ACC_LATCH, 3'd0), 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH0, 8'h12, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH0, 8'h34, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH0, 8'h00, 1'b1, 8'hFF});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH0, 8'h00, 1'b1, 8'hA5});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH0, 8'h00, 1'b0, 8'h00});
    // low byte only on channel 1
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, itpi_pkg::SEL_CTRL,
                            ctrl_word(SEL_CH1, itpi_pkg::ACC_LSB, 3'd0), 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH1, 8'h80, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH1, 8'h00, 1'b0, 8'h00});
    // high byte only on channel 2, with the bcd bit set
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, itpi_pkg::SEL_CTRL,
                            ctrl_word(SEL_CH2, itpi_pkg::ACC_MSB, 3'd5) | 8'h01,
                            1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH2, 8'h7F, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, itpi_pkg::SEL_CTRL,
                            ctrl_word(SEL_CH2, itpi_pkg::ACC_LATCH, 3'd0), 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_WRITE, SEL_CH2, 8'h01, 1'b1, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH2, 8'h00, 1'b0, 8'h00});
    directed_rows.push_back(access_row_t'{itpi_pkg::OP_READ, SEL_CH2, 8'h00, 1'b0, 8'h00});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_access(directed_rows[i].op, directed_rows[i].sel, directed_rows[i].wdata,
                  directed_rows[i].typed, directed_rows[i].want);

    // random part: control words of every shape (a quarter hit channel three,
    // a quarter latch), data writes and reads on the three channels, some
    // control reads; the read path ignores the data byte, so it is random too
    for (int n = 0; n < RANDOM_N; n++) begin
      pick  = $urandom_range(0, 99);
      wdata = itpi_pkg::BYTE_W'($urandom_range(0, 255));
      if (pick < 20) begin
        op  = itpi_pkg::OP_WRITE;
        sel = itpi_pkg::SEL_CTRL;
      end else if (pick < 55) begin
        op  = itpi_pkg::OP_WRITE;
        sel = 2'($urandom_range(0, itpi_pkg::NUM_CH - 1));
      end else if (pick < 92) begin
        op  = itpi_pkg::OP_READ;
        sel = 2'($urandom_range(0, itpi_pkg::NUM_CH - 1));
      end else begin
        op  = itpi_pkg::OP_READ;
        sel = itpi_pkg::SEL_CTRL;
      end
      send_access(op, sel, wdata, 1'b0, 8'h00);
    end
    in_tvalid <= 1'b0;

    // drain, then a short window that would catch any stray item
    while (owed_read_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
